// ----- rtl/rcls_pkg.sv -----
package rcls_pkg;

    // fixed field widths
    localparam int LETTER_W      = 5;
    localparam int TABLE_W       = 3;
    localparam int CMD_W         = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 5;
    localparam int MOD_IDX_W     = 7;
    localparam int MOD_LUT_DEPTH = 2 ** MOD_IDX_W;

    // default alphabet and pipeline shape
    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int NUM_TABLES        = 5;
    localparam int NUM_INV_TABLES    = 4;
    localparam int NUM_STAGES        = NUM_TABLES + NUM_INV_TABLES;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_START  = 2'd1,
        CMD_CIPHER = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // wiring table codes
    typedef enum logic [TABLE_W-1:0] {
        TBL_PLUG   = 3'd0,
        TBL_FAST   = 3'd1,
        TBL_MIDDLE = 3'd2,
        TBL_SLOW   = 3'd3,
        TBL_REFL   = 3'd4
    } t_table;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAST_START   = 2'd0,
        REG_MIDDLE_START = 2'd1,
        REG_SLOW_OFFSET  = 2'd2,
        REG_REFL_OFFSET  = 2'd3
    } t_cfg_reg;

    // one beat travelling down the lookup pipeline
    typedef struct packed {
        logic                valid;
        logic                cipher;
        logic                write;
        logic [TABLE_W-1:0]  sel;
        logic [LETTER_W-1:0] idx;
        logic [LETTER_W-1:0] val;
        logic [LETTER_W-1:0] fast_off;
        logic [LETTER_W-1:0] middle_off;
    } t_item;

    typedef logic [MOD_LUT_DEPTH-1:0][LETTER_W-1:0] t_mod_lut;

    // reduction table: entry i holds i mod a, built at elaboration
    function automatic t_mod_lut build_mod_lut(input int a);
        t_mod_lut lut;
        int       v;
        for (int i = 0; i < MOD_LUT_DEPTH; i++) begin
            v = i;
            for (int j = 0; j < MOD_LUT_DEPTH; j++) begin
                if (v >= a) begin
                    v = v - a;
                end
            end
            lut[i] = LETTER_W'(v);
        end
        return lut;
    endfunction

    // rotor offset that belongs to each pipeline stage
    function automatic logic [LETTER_W-1:0] stage_offset(
        input int                  stage,
        input logic [LETTER_W-1:0] fast_off,
        input logic [LETTER_W-1:0] middle_off,
        input logic [LETTER_W-1:0] slow_off,
        input logic [LETTER_W-1:0] refl_off
    );
        logic [LETTER_W-1:0] off;
        case (stage) inside
            1, 7:    off = fast_off;
            2, 6:    off = middle_off;
            3, 5:    off = slow_off;
            4:       off = refl_off;
            default: off = '0;
        endcase
        return off;
    endfunction

endpackage

// ----- rtl/rotor_cipher_letter_step.sv -----
// Rotor letter cipher. Letters are 0 to ALPHABET_SIZE-1. A command-0 beat writes one
// wiring entry (plugboard, fast, middle, slow rotor or reflector; the first four also
// fill their inverse), command 1 restarts the rotor counts, command 2 ciphers a letter
// and yields one letter_out beat; other beats yield nothing. The nine lookups run in a
// nine-stage pipeline, each stage owning a small synchronous memory with its own copy
// of one table, so one beat is taken every cycle while o_stall is low; wiring writes
// travel the same pipeline and so stay in order with letters. The whole pipeline holds
// while a finished letter waits under stall. The user must see that configuration
// registers are written only while no beat is in flight; the block does not enforce it.
module rotor_cipher_letter_step #(
    parameter int ALPHABET_SIZE = rcls_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rcls_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcls_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rcls_pkg::CMD_W-1:0]      i_command,
    input  logic [rcls_pkg::TABLE_W-1:0]    i_table_select,
    input  logic [rcls_pkg::LETTER_W-1:0]   i_table_index,
    input  logic [rcls_pkg::LETTER_W-1:0]   i_table_value,
    input  logic [rcls_pkg::LETTER_W-1:0]   i_letter_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rcls_pkg::LETTER_W-1:0]   o_letter_out
);
    import rcls_pkg::*;

    localparam t_mod_lut MOD_LUT = build_mod_lut(ALPHABET_SIZE);

    logic [CFG_DATA_W-1:0] r_fast_start, r_middle_start, r_slow_offset, r_refl_offset;
    logic [LETTER_W-1:0]   r_fast_count, r_middle_count;
    logic [LETTER_W-1:0]   n_fast_count, n_middle_count;
    logic                  r_out_valid;
    logic [LETTER_W-1:0]   r_letter_out;

    logic                  adv;
    logic                  accept;
    logic                  write_ok;
    logic                  fast_wrap;
    logic [LETTER_W-1:0]   fast_start_m, middle_start_m, slow_m, refl_m;
    t_item                 entry;

    t_item                 stg_item   [NUM_STAGES];
    logic [LETTER_W-1:0]   stg_letter [NUM_STAGES];
    logic [LETTER_W-1:0]   stg_off    [NUM_STAGES];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_start   <= '0;
            r_middle_start <= '0;
            r_slow_offset  <= '0;
            r_refl_offset  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FAST_START:   r_fast_start   <= i_cfg_data;
                REG_MIDDLE_START: r_middle_start <= i_cfg_data;
                REG_SLOW_OFFSET:  r_slow_offset  <= i_cfg_data;
                REG_REFL_OFFSET:  r_refl_offset  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // offsets reduced into the alphabet
    assign fast_start_m   = MOD_LUT[MOD_IDX_W'(r_fast_start)];
    assign middle_start_m = MOD_LUT[MOD_IDX_W'(r_middle_start)];
    assign slow_m         = MOD_LUT[MOD_IDX_W'(r_slow_offset)];
    assign refl_m         = MOD_LUT[MOD_IDX_W'(r_refl_offset)];

    // pipeline moves whenever the output register is free or drained
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    // entry beat
    assign write_ok = (t_cmd'(i_command) == CMD_WRITE)
                   && (i_table_select <= TABLE_W'(TBL_REFL))
                   && (MOD_IDX_W'(i_table_index) < MOD_IDX_W'(ALPHABET_SIZE))
                   && (MOD_IDX_W'(i_table_value) < MOD_IDX_W'(ALPHABET_SIZE));

    always_comb begin
        entry            = '0;
        entry.cipher     = (t_cmd'(i_command) == CMD_CIPHER);
        entry.write      = write_ok;
        entry.valid      = accept && (entry.cipher || write_ok);
        entry.sel        = i_table_select;
        entry.idx        = i_table_index;
        entry.val        = i_table_value;
        entry.fast_off   = MOD_LUT[MOD_IDX_W'(fast_start_m) + MOD_IDX_W'(r_fast_count)];
        entry.middle_off = MOD_LUT[MOD_IDX_W'(middle_start_m) + MOD_IDX_W'(r_middle_count)];
    end

    // rotor stepping
    assign fast_wrap = (MOD_IDX_W'(r_fast_count) + MOD_IDX_W'(1))
                    >= MOD_IDX_W'(ALPHABET_SIZE);

    always_comb begin
        n_fast_count   = r_fast_count;
        n_middle_count = r_middle_count;
        if (accept) begin
            unique case (t_cmd'(i_command))
                CMD_START: begin
                    n_fast_count   = '0;
                    n_middle_count = '0;
                end
                CMD_CIPHER: begin
                    if (fast_wrap) begin
                        n_fast_count = '0;
                        if ((MOD_IDX_W'(r_middle_count) + MOD_IDX_W'(1))
                                >= MOD_IDX_W'(ALPHABET_SIZE)) begin
                            n_middle_count = '0;
                        end else begin
                            n_middle_count = r_middle_count + LETTER_W'(1);
                        end
                    end else begin
                        n_fast_count = r_fast_count + LETTER_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_count   <= '0;
            r_middle_count <= '0;
        end else begin
            r_fast_count   <= n_fast_count;
            r_middle_count <= n_middle_count;
        end
    end

    // nine lookup stages
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        t_item               up_item;
        logic [LETTER_W-1:0] up_letter;
        logic [LETTER_W-1:0] up_off;

        if (k == 0) begin : g_first
            assign up_item   = entry;
            assign up_letter = i_letter_in;
            assign up_off    = '0;
        end else begin : g_next
            assign up_item   = stg_item[k-1];
            assign up_letter = stg_letter[k-1];
            assign up_off    = stg_off[k-1];
        end

        rcls_stage #(
            .ALPHABET_SIZE (ALPHABET_SIZE),
            .STAGE         (k)
        ) u_stage (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_item     (up_item),
            .i_letter   (up_letter),
            .i_prev_off (up_off),
            .i_slow_off (slow_m),
            .i_refl_off (refl_m),
            .o_item     (stg_item[k]),
            .o_letter   (stg_letter[k]),
            .o_off      (stg_off[k])
        );
    end

    // output register; last stage has offset zero so the lookup is the letter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= stg_item[NUM_STAGES-1].valid && stg_item[NUM_STAGES-1].cipher;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_letter_out <= stg_letter[NUM_STAGES-1];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_letter_out = r_letter_out;

endmodule

// ----- rtl/rcls_ram.sv -----
module rcls_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rcls_stage.sv -----
module rcls_stage #(
    parameter int ALPHABET_SIZE = rcls_pkg::ALPHABET_SIZE_DEF,
    parameter int STAGE         = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  rcls_pkg::t_item               i_item,
    input  logic [rcls_pkg::LETTER_W-1:0] i_letter,
    input  logic [rcls_pkg::LETTER_W-1:0] i_prev_off,
    input  logic [rcls_pkg::LETTER_W-1:0] i_slow_off,
    input  logic [rcls_pkg::LETTER_W-1:0] i_refl_off,
    output rcls_pkg::t_item               o_item,
    output logic [rcls_pkg::LETTER_W-1:0] o_letter,
    output logic [rcls_pkg::LETTER_W-1:0] o_off
);
    import rcls_pkg::*;

    localparam int       AW      = $clog2(ALPHABET_SIZE);
    localparam bit       INVERSE = (STAGE >= NUM_TABLES);
    localparam int       TBL     = INVERSE ? (NUM_STAGES - 1 - STAGE) : STAGE;
    localparam t_mod_lut MOD_LUT = build_mod_lut(ALPHABET_SIZE);

    t_item                 r_item;
    logic [LETTER_W-1:0]   next_off;
    logic [MOD_IDX_W-1:0]  raw_idx;
    logic [AW-1:0]         raddr;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [LETTER_W-1:0]   wdata;

    // undo the previous offset, apply this stage's offset, reduce
    assign next_off = stage_offset(STAGE, i_item.fast_off, i_item.middle_off,
                                   i_slow_off, i_refl_off);
    assign raw_idx  = MOD_IDX_W'(i_letter) + MOD_IDX_W'(ALPHABET_SIZE)
                    - MOD_IDX_W'(i_prev_off) + MOD_IDX_W'(next_off);
    assign raddr    = MOD_LUT[raw_idx][AW-1:0];

    // wiring write as the beat passes this stage; inverse swaps index and value
    assign we    = i_adv && i_item.valid && i_item.write
                && (i_item.sel == TABLE_W'(TBL));
    assign waddr = INVERSE ? i_item.val[AW-1:0] : i_item.idx[AW-1:0];
    assign wdata = INVERSE ? i_item.idx : i_item.val;

    rcls_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_adv),
        .i_raddr (raddr),
        .o_rdata (o_letter)
    );

    // beat register alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else if (i_adv) begin
            r_item <= i_item;
        end
    end

    assign o_item = r_item;
    assign o_off  = stage_offset(STAGE, r_item.fast_off, r_item.middle_off,
                                 i_slow_off, i_refl_off);

endmodule

// ----- rtl/rcls_checker.sv -----
module rcls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_index,
    input logic [4:0] i_cfg_data,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_command,
    input logic [2:0] i_table_select,
    input logic [4:0] i_table_index,
    input logic [4:0] i_table_value,
    input logic [4:0] i_letter_in,
    input logic       o_valid,
    input logic       i_stall,
    input logic [4:0] o_letter_out
);

    // a result held under stall keeps its letter
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_letter_out))
        else $error("output beat changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // input is held back only by a waiting, stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // a blocked result always holds back the input
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while result blocked");

endmodule

bind rotor_cipher_letter_step rcls_checker u_rcls_checker (.*);
